@@ hdl/rmte_pkg.sv @@
// Shared types, constants and helper functions for the Z-Y-X Euler angle extractor.
`timescale 1ns / 1ps
package rmte_pkg;

   localparam int unsigned ELEM_W      = 16;   // matrix element, Q2.14
   localparam int unsigned OPND_W      = 17;   // arctangent operand before scaling
   localparam int unsigned XY_W        = 36;   // CORDIC x/y, operand scaled by 2^16
   localparam int unsigned Z_W         = 28;   // angle accumulator, Q24 radians
   localparam int unsigned SQ_W        = 30;   // square-root remainder and root
   localparam int unsigned SQ_STEPS    = 15;   // digit pairs of a 29-bit radicand
   localparam int unsigned THR_W       = 15;
   localparam int unsigned ANG_TAB_LEN = 24;
   localparam int unsigned OUT_W       = 16;

   localparam logic signed [ELEM_W-1:0] ONE_Q14   = 16'sd16384;
   localparam logic signed [Z_W-1:0]    PI_Q24    = 28'sd52707179;
   localparam logic signed [17:0]       ROLL_MAX  = 18'sd25736;
   localparam logic signed [17:0]       PITCH_MAX = 18'sd12868;
   localparam logic [THR_W-1:0]         THR_RESET = 15'd1;

   localparam logic signed [Z_W-1:0] ANG_TAB [0:ANG_TAB_LEN-1] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
      28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
      28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
      28'sd256,      28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2
   };

   // Matrix elements and clamped sine of pitch, carried alongside the root
   typedef struct packed {
      logic signed [ELEM_W-1:0] m00;
      logic signed [ELEM_W-1:0] m01;
      logic signed [ELEM_W-1:0] m02;
      logic signed [ELEM_W-1:0] m10;
      logic signed [ELEM_W-1:0] m21;
      logic signed [ELEM_W-1:0] m22;
      logic signed [ELEM_W-1:0] s;
   } mat_type;

   typedef struct packed {
      logic [SQ_W-1:0] n;
      logic [SQ_W-1:0] r;
   } sqrt_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   done;
   } cordic_type;

   // Fold the left half-plane and settle the trivial cases before rotation
   function automatic cordic_type cordic_init(input logic signed [OPND_W-1:0] y,
                                              input logic signed [OPND_W-1:0] x);
      cordic_type o;
      logic signed [OPND_W-1:0] xa;
      logic signed [OPND_W-1:0] ya;
      o.z    = '0;
      o.done = 1'b0;
      xa     = x;
      ya     = y;
      if (x == '0 && y == '0) begin
         o.done = 1'b1;
      end else begin
         if (x < 0) begin
            o.z = (y >= 0) ? PI_Q24 : -PI_Q24;
            xa  = -x;
            ya  = -y;
         end
         if (ya == '0) begin
            o.done = 1'b1;
         end
      end
      o.x = {{(XY_W-OPND_W-16){xa[OPND_W-1]}}, xa, 16'b0};
      o.y = {{(XY_W-OPND_W-16){ya[OPND_W-1]}}, ya, 16'b0};
      return o;
   endfunction

   // Round Q24 to Q3.13, saturate, negate
   function automatic logic [OUT_W-1:0] to_out(input logic signed [Z_W-1:0] z,
                                               input logic signed [17:0] lim);
      logic signed [Z_W:0]  t;
      logic signed [17:0]   a;
      logic signed [17:0]   neg;
      t = {z[Z_W-1], z} + (Z_W+1)'(1024);
      a = $signed(t[Z_W:11]);
      if (a > lim) begin
         a = lim;
      end
      if (a < -lim) begin
         a = -lim;
      end
      neg = -a;
      return neg[OUT_W-1:0];
   endfunction

endpackage

@@ hdl/rmte_req_if.sv @@
// Channel interfaces: matrix input, angle result and threshold write.
`timescale 1ns / 1ps
interface rmte_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] m00;
   logic [15:0] m01;
   logic [15:0] m02;
   logic [15:0] m10;
   logic [15:0] m20;
   logic [15:0] m21;
   logic [15:0] m22;
   modport source (output valid, m00, m01, m02, m10, m20, m21, m22, input ready);
   modport sink   (input valid, m00, m01, m02, m10, m20, m21, m22, output ready);
endinterface

interface rmte_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] roll_angle;
   logic [14:0] pitch_angle;
   logic [15:0] yaw_angle;
   logic        gimbal_lock;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
                   input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
                   output ready);
endinterface

interface rmte_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ hdl/rmte_sqrt_cell.sv @@
// One digit-pair step of the integer square root, with its payload register.
`timescale 1ns / 1ps
module rmte_sqrt_cell import rmte_pkg::*; #(
   parameter int unsigned K = 0
) (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type d_in,
   input  mat_type  m_in,
   output sqrt_type d_out,
   output mat_type  m_out
);

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

   sqrt_type        d_in_w;
   sqrt_type        d_ff;
   mat_type         m_ff;
   logic [SQ_W-1:0] trial;

   // Try the next root bit, keep it if the remainder allows
   always_comb begin
      trial = d_in.r + BIT;
      if (d_in.n >= trial) begin
         d_in_w.n = d_in.n - trial;
         d_in_w.r = (d_in.r >> 1) + BIT;
      end else begin
         d_in_w.n = d_in.n;
         d_in_w.r = d_in.r >> 1;
      end
   end

   // Advance on enable
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_w;
         m_ff <= m_in;
      end
   end

   assign d_out = d_ff;
   assign m_out = m_ff;

endmodule

@@ hdl/rmte_cordic_cell.sv @@
// One CORDIC vectoring micro-rotation with its state register.
`timescale 1ns / 1ps
module rmte_cordic_cell import rmte_pkg::*; #(
   parameter int unsigned I = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type d_in,
   output cordic_type d_out
);

   cordic_type             d_in_w;
   cordic_type             d_ff;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;

   // Rotate towards the x axis unless already settled
   always_comb begin
      dx     = d_in.y >>> I;
      dy     = d_in.x >>> I;
      d_in_w = d_in;
      if (!d_in.done) begin
         if (d_in.y >= 0) begin
            d_in_w.x = d_in.x + dx;
            d_in_w.y = d_in.y - dy;
            d_in_w.z = d_in.z + ANG_TAB[I];
         end else begin
            d_in_w.x = d_in.x - dx;
            d_in_w.y = d_in.y + dy;
            d_in_w.z = d_in.z - ANG_TAB[I];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_w;
      end
   end

   assign d_out = d_ff;

endmodule

@@ hdl/rotation_matrix_to_euler_zyx.sv @@
// Top level: Z-Y-X Euler angles from a Q2.14 rotation matrix.
//
// Usage:
//  - req_ch carries the seven used matrix elements (Q2.14). A transaction is
//    taken when valid and ready are both high; ready is high unless a finished
//    result is waiting on rsp_ch and the receiver holds ready low.
//  - rsp_ch returns negated roll, pitch and yaw in radians (roll and yaw Q3.13,
//    pitch Q2.13), the gimbal lock flag, one result per input transaction, in order.
//  - csr_ch writes the gimbal threshold (unsigned Q1.14); it is always ready. Write it
//    only while no transactions are in flight.
//  - Throughput: one matrix per cycle unless rsp_ch stalls. Each cell of the
//    square-root chain and of the three parallel CORDIC chains holds one matrix.
//  - Path from acceptance to the result register: input stage, radicand
//    stage, 15 root cells, operand selection, one cell per CORDIC stage
//    (min(CORDIC_ITERATIONS, 24) of them), output register.
//  - Reset (synchronous, active high) empties the pipeline and sets the
//    threshold to 1.
//  - While the receiver stalls, the whole chain holds and the result stays put.
`timescale 1ns / 1ps
module rotation_matrix_to_euler_zyx import rmte_pkg::*; #(
   parameter int unsigned CORDIC_ITERATIONS = 16
) (
   input  logic      clock,
   input  logic      reset,
   rmte_req_if.sink   req_ch,
   rmte_rsp_if.source rsp_ch,
   rmte_csr_if.sink   csr_ch
);

   localparam int unsigned NCELL =
      (CORDIC_ITERATIONS > ANG_TAB_LEN) ? ANG_TAB_LEN : CORDIC_ITERATIONS;

   logic en;

   logic [THR_W-1:0] thr_ff;

   logic             in_v_ff;
   logic [ELEM_W-1:0] m00_ff, m01_ff, m02_ff, m10_ff, m20_ff, m21_ff, m22_ff;

   logic                      n_v_ff;
   mat_type                   mat_in, mat_ff;
   logic [SQ_W-1:0]           n_in, n_ff;
   logic signed [ELEM_W:0]    neg_m20;
   logic signed [ELEM_W-1:0]  s_w;
   logic signed [2*ELEM_W-1:0] s_sq;

   sqrt_type sq_d [0:SQ_STEPS];
   mat_type  sq_m [0:SQ_STEPS];
   logic [SQ_STEPS-1:0] sq_v_ff;

   logic [THR_W-1:0]         c_w;
   logic                     lock_w;
   logic signed [OPND_W-1:0] ry_w, rx_w;
   logic                     prep_v_ff;
   logic                     prep_lock_ff;

   cordic_type pc [0:NCELL];
   cordic_type rc [0:NCELL];
   cordic_type yc [0:NCELL];
   logic [NCELL-1:0] c_v_ff;
   logic [NCELL-1:0] c_lock_ff;

   logic              rsp_v_ff;
   logic [OUT_W-1:0]  roll_ff, yaw_ff;
   logic [OUT_W-1:0]  pitch_full;
   logic [OUT_W-2:0]  pitch_ff;
   logic              lock_ff;

   // Whole chain advances unless a result is stuck at the output
   assign en           = !rsp_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;
   assign csr_ch.ready = 1'b1;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_ch.valid) begin
         thr_ff <= csr_ch.data;
      end
   end

   // Capture input transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m00_ff <= req_ch.m00;
         m01_ff <= req_ch.m01;
         m02_ff <= req_ch.m02;
         m10_ff <= req_ch.m10;
         m20_ff <= req_ch.m20;
         m21_ff <= req_ch.m21;
         m22_ff <= req_ch.m22;
      end
   end

   // Clamp sine of pitch and form the radicand 1 - s^2
   always_comb begin
      neg_m20 = -$signed({m20_ff[ELEM_W-1], m20_ff});
      if (neg_m20 > $signed({1'b0, ONE_Q14})) begin
         s_w = ONE_Q14;
      end else if (neg_m20 < -$signed({1'b0, ONE_Q14})) begin
         s_w = -ONE_Q14;
      end else begin
         s_w = neg_m20[ELEM_W-1:0];
      end
      s_sq       = s_w * s_w;
      n_in       = (SQ_W'(1) << 28) - SQ_W'(s_sq);
      mat_in.m00 = m00_ff;
      mat_in.m01 = m01_ff;
      mat_in.m02 = m02_ff;
      mat_in.m10 = m10_ff;
      mat_in.m21 = m21_ff;
      mat_in.m22 = m22_ff;
      mat_in.s   = s_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
      end else if (en) begin
         n_v_ff <= in_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff   <= n_in;
         mat_ff <= mat_in;
      end
   end

   // Square-root chain, most significant digit pair first
   assign sq_d[0].n = n_ff;
   assign sq_d[0].r = '0;
   assign sq_m[0]   = mat_ff;

   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
      rmte_sqrt_cell #(.K(SQ_STEPS - 1 - g)) u_cell (
         .clock (clock),
         .en    (en),
         .d_in  (sq_d[g]),
         .m_in  (sq_m[g]),
         .d_out (sq_d[g+1]),
         .m_out (sq_m[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
      end else if (en) begin
         sq_v_ff <= {sq_v_ff[SQ_STEPS-2:0], n_v_ff};
      end
   end

   // Decide gimbal lock and pick the roll operands
   always_comb begin
      c_w    = sq_d[SQ_STEPS].r[THR_W-1:0];
      lock_w = (c_w <= thr_ff);
      if (!lock_w) begin
         ry_w = OPND_W'(sq_m[SQ_STEPS].m21);
         rx_w = OPND_W'(sq_m[SQ_STEPS].m22);
      end else if (sq_m[SQ_STEPS].s > 0) begin
         ry_w = OPND_W'(sq_m[SQ_STEPS].m01);
         rx_w = OPND_W'(sq_m[SQ_STEPS].m02);
      end else begin
         ry_w = -OPND_W'(sq_m[SQ_STEPS].m01);
         rx_w = -OPND_W'(sq_m[SQ_STEPS].m02);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_v_ff <= 1'b0;
      end else if (en) begin
         prep_v_ff <= sq_v_ff[SQ_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_lock_ff <= lock_w;
         pc[0] <= cordic_init(OPND_W'(sq_m[SQ_STEPS].s), OPND_W'($signed({1'b0, c_w})));
         rc[0] <= cordic_init(ry_w, rx_w);
         yc[0] <= cordic_init(OPND_W'(sq_m[SQ_STEPS].m10), OPND_W'(sq_m[SQ_STEPS].m00));
      end
   end

   // Three CORDIC chains side by side
   for (genvar g = 0; g < NCELL; g++) begin : g_cordic
      rmte_cordic_cell #(.I(g)) u_pitch (
         .clock (clock), .en (en), .d_in (pc[g]), .d_out (pc[g+1]));
      rmte_cordic_cell #(.I(g)) u_roll (
         .clock (clock), .en (en), .d_in (rc[g]), .d_out (rc[g+1]));
      rmte_cordic_cell #(.I(g)) u_yaw (
         .clock (clock), .en (en), .d_in (yc[g]), .d_out (yc[g+1]));
   end

   // Valid and lock flag travel with the CORDIC cells
   if (NCELL > 1) begin : g_line
      always_ff @(posedge clock) begin
         if (reset) begin
            c_v_ff <= '0;
         end else if (en) begin
            c_v_ff <= {c_v_ff[NCELL-2:0], prep_v_ff};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            c_lock_ff <= {c_lock_ff[NCELL-2:0], prep_lock_ff};
         end
      end
   end else begin : g_line1
      always_ff @(posedge clock) begin
         if (reset) begin
            c_v_ff <= '0;
         end else if (en) begin
            c_v_ff <= prep_v_ff;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            c_lock_ff <= prep_lock_ff;
         end
      end
   end

   // Output register
   assign pitch_full = to_out(pc[NCELL].z, PITCH_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= c_v_ff[NCELL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= to_out(rc[NCELL].z, ROLL_MAX);
         pitch_ff <= pitch_full[OUT_W-2:0];
         yaw_ff   <= c_lock_ff[NCELL-1] ? '0 : to_out(yc[NCELL].z, ROLL_MAX);
         lock_ff  <= c_lock_ff[NCELL-1];
      end
   end

   assign rsp_ch.valid       = rsp_v_ff;
   assign rsp_ch.roll_angle  = roll_ff;
   assign rsp_ch.pitch_angle = pitch_ff;
   assign rsp_ch.yaw_angle   = yaw_ff;
   assign rsp_ch.gimbal_lock = lock_ff;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the Z-Y-X Euler angle extractor.
`timescale 1ns / 1ps
module tb;
   import rmte_pkg::*;

   typedef struct {
      logic [15:0] roll;
      logic [14:0] pitch;
      logic [15:0] yaw;
      logic        lock;
   } angle_set_type;

   // Scoreboard: computes the expected angles of each accepted matrix and checks results
   class angle_scoreboard;
      angle_set_type pending[$];
      logic [14:0] threshold;
      int          errors;
      int          checked;
      int          locks;

      function new();
         threshold = THR_RESET;
         errors    = 0;
         checked   = 0;
         locks     = 0;
      endfunction

      function automatic longint fshr(longint v, int s);
         return v >>> s;
      endfunction

      function automatic longint isqrt(longint n);
         longint r;
         longint b;
         r = 0;
         b = 64'd1 << 30;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Vectoring arctangent, radians scaled by 2^24
      function automatic longint arctan2(longint y, longint x);
         longint z;
         longint dx;
         longint dy;
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
            x = -x;
            y = -y;
         end
         if (y == 0) return z;
         x = x * 65536;
         y = y * 65536;
         for (int i = 0; i < 16; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
               x = x + dx; y = y - dy; z = z + ANG_TAB[i];
            end else begin
               x = x - dx; y = y + dy; z = z - ANG_TAB[i];
            end
         end
         return z;
      endfunction

      function automatic logic [15:0] scale_out(longint z, longint lim);
         longint a;
         a = fshr(z + 1024, 11);
         if (a > lim) a = lim;
         if (a < -lim) a = -lim;
         a = -a;
         return a[15:0];
      endfunction

      function void note_matrix(logic signed [15:0] m00, m01, m02, m10, m20, m21, m22);
         angle_set_type e;
         longint  s;
         longint  c;
         longint  roll;
         longint  pitch;
         logic [15:0] p;
         s = -longint'(m20);
         if (s > 16384) s = 16384;
         if (s < -16384) s = -16384;
         c = isqrt(64'd268435456 - s * s);
         pitch = arctan2(s, c);
         e.lock = (c <= threshold);
         e.yaw  = '0;
         if (!e.lock) begin
            roll  = arctan2(m21, m22);
            e.yaw = scale_out(arctan2(m10, m00), 25736);
         end else if (s > 0) begin
            roll = arctan2(m01, m02);
         end else begin
            roll = arctan2(-longint'(m01), -longint'(m02));
         end
         e.roll  = scale_out(roll, 25736);
         p       = scale_out(pitch, 12868);
         e.pitch = p[14:0];
         pending = {pending, e};
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         $display("mismatch on %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      task check_angles(logic [15:0] roll, logic [14:0] pitch, logic [15:0] yaw,
                        logic lock);
         angle_set_type e;
         if (pending.size() == 0) begin
            $display("result with no matrix outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (lock) locks++;
         if (roll !== e.roll) report("roll", roll, e.roll);
         if (pitch !== e.pitch) report("pitch", 16'(pitch), 16'(e.pitch));
         if (yaw !== e.yaw) report("yaw", yaw, e.yaw);
         if (lock !== e.lock) report("gimbal_lock", 16'(lock), 16'(e.lock));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmte_req_if req_ch ();
   rmte_rsp_if rsp_ch ();
   rmte_csr_if csr_ch ();

   rotation_matrix_to_euler_zyx dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   angle_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  long_hold = 1'b0;
   bit  timed_out = 1'b0;
   int  sent = 0;
   localparam int WATCHDOG = 4000;

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.m00, req_ch.m01, req_ch.m02, req_ch.m10} = '0;
      {req_ch.m20, req_ch.m21, req_ch.m22} = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   // Note accepted matrices and check results at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_matrix(req_ch.m00, req_ch.m01, req_ch.m02, req_ch.m10,
                           req_ch.m20, req_ch.m21, req_ch.m22);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_angles(rsp_ch.roll_angle, rsp_ch.pitch_angle, rsp_ch.yaw_angle,
                            rsp_ch.gimbal_lock);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver: random stall bursts, one long hold on request, none at the end
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (120) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_matrix(logic [15:0] m00, m01, m02, m10, m20, m21, m22);
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 13);
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.m00 <= m00; req_ch.m01 <= m01; req_ch.m02 <= m02; req_ch.m10 <= m10;
      req_ch.m20 <= m20; req_ch.m21 <= m21; req_ch.m22 <= m22;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_threshold(logic [14:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      sb.threshold = value;
   endtask

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   // Random element, mostly within [-1, 1] with the odd extreme thrown in
   function automatic logic [15:0] elem();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return rnd16();
      if (sel == 1) return ($urandom_range(0, 1)) ? 16'h4000 : 16'hC000;
      if (sel == 2) return '0;
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic random_matrix();
      logic [15:0] m20;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) m20 = ($urandom_range(0, 1)) ? 16'h4000 : 16'hC000;
      else if (sel < 4) m20 = 16'($signed($urandom_range(16370, 16384))
                                   * (($urandom_range(0, 1)) ? 1 : -1));
      else m20 = elem();
      send_matrix(elem(), elem(), elem(), elem(), m20, elem(), elem());
   endtask

   initial begin
      logic [14:0] thr_list[5];
      thr_list = '{15'd0, 15'd300, 15'd16384, 15'h7FFF, 15'd1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero operands, both gimbal-lock signs
      send_matrix(16'h4000, 0, 0, 0, 0, 0, 16'h4000);
      send_matrix(0, 0, 0, 0, 0, 0, 0);
      send_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_matrix(16'hC000, 16'h1234, 16'hC000, 0, 0, 0, 16'hC000);
      send_matrix(16'hC000, 0, 0, 16'h2000, 0, 16'hE000, 16'hC000);
      send_matrix(0, 16'h4000, 0, 16'h4000, 16'hC000, 16'h4000, 0);
      send_matrix(0, 16'hC000, 0, 16'hC000, 16'h4000, 16'hC000, 0);
      send_matrix(0, 16'h2D41, 16'h2D41, 0, 16'hC000, 0, 0);
      send_matrix(0, 16'h2D41, 16'hD2BF, 0, 16'h4000, 0, 0);
      send_matrix(0, 0, 16'hC000, 0, 16'hC000, 0, 0);
      send_matrix(0, 0, 16'h4000, 0, 16'h4000, 0, 0);
      send_matrix(16'h3000, 0, 0, 16'hD000, 16'h2000, 16'h1000, 16'h3000);
      send_matrix(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF);

      // Random phases over several thresholds
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(thr_list[ph]);
         for (int i = 0; i < 90; i++) begin
            if (ph == 1 && i == 30) long_hold = 1'b1;
            if (ph == 2 && i == 40) drain();
            if (ph == 4 && i == 50) quiet = 1'b1;
            random_matrix();
         end
      end
      write_threshold(15'($urandom_range(1, 16384)));
      for (int i = 0; i < 40; i++) random_matrix();
      drain();
   end

   // Completion and watchdog
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG) begin
            timed_out = 1'b1;
            break;
         end
         if (quiet && sent >= 504 && sb.pending.size() == 0 && !req_ch.valid
             && idle_cycles > 40) break;
      end
      if (timed_out) begin
         $display("watchdog expired, %0d results outstanding", sb.pending.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         $display("checked %0d angle results over 6 thresholds, %0d in gimbal lock",
                  sb.checked, sb.locks);
         if (sb.errors == 0) begin
            $display("TB_OK");
         end else begin
            $display("TB_ERROR");
         end
         $finish;
      end
   end
endmodule
